// ----- rtl/ttsd_pkg.sv -----
// ----------------------------------------------------------------------------
// ttsd_pkg
// Shared constants, the search-pipeline item type and the odd-square table
// for the touch-to-stick deadzone mapper.
// ----------------------------------------------------------------------------
package ttsd_pkg;

  // default number of fraction bits in a touch coordinate
  localparam int unsigned TTSD_COORD_FRAC_BITS = 4;

  // stick travel radius after reset, sixteenths of a point
  localparam logic [15:0] TTSD_RADIUS_RESET = 16'd1600;

  // full-scale stick magnitude and the bits of the magnitude search
  localparam int unsigned TTSD_STICK_MAX = 80;
  localparam int unsigned TTSD_KBITS     = 7;

  // one item in flight through the magnitude search
  typedef struct packed {
    logic [31:0] d2;      // squared divisor, max(dx^2 + dy^2, r^2)
    logic [45:0] lim_x;   // (160 * |x|)^2
    logic [45:0] lim_y;   // (160 * |y|)^2
    logic        kill_x;  // x forced to zero (deadzone or small radius)
    logic        kill_y;  // y forced to zero (deadzone or small radius)
    logic        neg_x;   // x result is negative
    logic        neg_y;   // y result is negative
    logic [6:0]  k_x;     // magnitude found so far
    logic [6:0]  k_y;
    logic [15:0] osq_x;   // (2t-1)^2 for the trial of the next step
    logic [15:0] osq_y;
  } ttsd_srch_t;

  // (2t-1)^2 for a 7-bit trial magnitude, a 128-entry constant table
  function automatic logic [15:0] odd_sq(input logic [6:0] t);
    logic [7:0] odd;
    odd = {t, 1'b0} - 8'd1;
    return 16'(odd) * 16'(odd);
  endfunction

endpackage

// ----- rtl/ttsd_front.sv -----
// ----------------------------------------------------------------------------
// ttsd_front
// Front stages: offset magnitudes and signs, squares, squared divisor and
// per-axis deadzone test. Four register stages, one item per cycle while adv_i is high.
// ----------------------------------------------------------------------------
module ttsd_front #(
  parameter int unsigned COORD_FRAC_BITS = ttsd_pkg::TTSD_COORD_FRAC_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      vld_i,
  input  logic signed [15:0]        dx_i,
  input  logic signed [15:0]        dy_i,
  input  logic        [15:0]        radius_i,
  output logic                      vld_o,
  output ttsd_pkg::ttsd_srch_t      item_o
);
  import ttsd_pkg::*;

  localparam logic [15:0] SmallRadius = 16'(2 ** COORD_FRAC_BITS);

  // stage a: magnitudes and signs
  logic        a_vld_q;
  logic [15:0] ax_a_q, ay_a_q, r_a_q;
  logic        xn_a_q, yn_a_q, small_a_q;

  // stage b: squares
  logic        b_vld_q;
  logic [31:0] ax2_b_q, ay2_b_q, r2_b_q;
  logic [45:0] limx_b_q, limy_b_q;
  logic        xn_b_q, yn_b_q, small_b_q;

  // stage c: squared divisor and deadzone products
  logic        c_vld_q;
  logic [31:0] d2_c_q;
  logic [41:0] dzx_c_q, dzy_c_q;
  logic [45:0] limx_c_q, limy_c_q;
  logic        xn_c_q, yn_c_q, small_c_q;

  // stage d: output item
  logic        d_vld_q;
  ttsd_srch_t  item_q;

  logic [22:0] ax160, ay160;
  logic [32:0] sum_sq;
  logic [31:0] d2_d;

  // 160 * a by shift and add
  assign ax160 = {ax_a_q, 7'b0} + {2'b0, ax_a_q, 5'b0};
  assign ay160 = {ay_a_q, 7'b0} + {2'b0, ay_a_q, 5'b0};

  // squared length, never above 2^31, then the larger of it and r^2
  assign sum_sq = 33'(ax2_b_q) + 33'(ay2_b_q);
  assign d2_d   = (sum_sq > 33'(r2_b_q)) ? sum_sq[31:0] : r2_b_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else if (adv_i) begin
      a_vld_q <= vld_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
    end
  end

  // data path
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      // y is inverted, so a positive dy gives a negative stick value
      ax_a_q    <= dx_i[15] ? 16'(-dx_i) : 16'(dx_i);
      ay_a_q    <= dy_i[15] ? 16'(-dy_i) : 16'(dy_i);
      xn_a_q    <= dx_i[15];
      yn_a_q    <= !dy_i[15];
      small_a_q <= (radius_i <= SmallRadius);
      r_a_q     <= radius_i;

      ax2_b_q   <= 32'(ax_a_q) * 32'(ax_a_q);
      ay2_b_q   <= 32'(ay_a_q) * 32'(ay_a_q);
      r2_b_q    <= 32'(r_a_q) * 32'(r_a_q);
      limx_b_q  <= 46'(ax160) * 46'(ax160);
      limy_b_q  <= 46'(ay160) * 46'(ay160);
      xn_b_q    <= xn_a_q;
      yn_b_q    <= yn_a_q;
      small_b_q <= small_a_q;

      d2_c_q    <= d2_d;
      dzx_c_q   <= 42'(ax2_b_q) * 42'd625;
      dzy_c_q   <= 42'(ay2_b_q) * 42'd625;
      limx_c_q  <= limx_b_q;
      limy_c_q  <= limy_b_q;
      xn_c_q    <= xn_b_q;
      yn_c_q    <= yn_b_q;
      small_c_q <= small_b_q;

      // deadzone: 625 a^2 < 4 d2, search starts with trial 64
      item_q.d2     <= d2_c_q;
      item_q.lim_x  <= limx_c_q;
      item_q.lim_y  <= limy_c_q;
      item_q.kill_x <= small_c_q || (dzx_c_q < 42'({d2_c_q, 2'b00}));
      item_q.kill_y <= small_c_q || (dzy_c_q < 42'({d2_c_q, 2'b00}));
      item_q.neg_x  <= xn_c_q;
      item_q.neg_y  <= yn_c_q;
      item_q.k_x    <= '0;
      item_q.k_y    <= '0;
      item_q.osq_x  <= odd_sq(7'(2 ** (TTSD_KBITS - 1)));
      item_q.osq_y  <= odd_sq(7'(2 ** (TTSD_KBITS - 1)));
    end
  end

  assign vld_o  = d_vld_q;
  assign item_o = item_q;

endmodule

// ----- rtl/ttsd_step.sv -----
// ----------------------------------------------------------------------------
// ttsd_step
// One bit of the magnitude search: tries setting bit BIT of k on both axes,
// keeps it when the trial is not above 80 and (2k-1)^2 * d2 <= (160 a)^2,
// and looks up the odd square for the following bit.
// ----------------------------------------------------------------------------
module ttsd_step #(
  parameter int BIT = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 vld_i,
  input  ttsd_pkg::ttsd_srch_t item_i,
  output logic                 vld_o,
  output ttsd_pkg::ttsd_srch_t item_o
);
  import ttsd_pkg::*;

  localparam int         NextBit  = (BIT > 0) ? BIT - 1 : 0;
  localparam logic [6:0] Step     = 7'(2 ** BIT);
  localparam logic [6:0] NextStep = 7'(2 ** NextBit);

  logic       vld_q;
  ttsd_srch_t item_d, item_q;

  logic [6:0]  trial_x, trial_y;
  logic [47:0] prod_x, prod_y;
  logic        take_x, take_y;

  // trial compare on both axes
  assign trial_x = item_i.k_x | Step;
  assign trial_y = item_i.k_y | Step;
  assign prod_x  = 48'(item_i.osq_x) * 48'(item_i.d2);
  assign prod_y  = 48'(item_i.osq_y) * 48'(item_i.d2);
  assign take_x  = (trial_x <= 7'(TTSD_STICK_MAX)) && (prod_x <= 48'(item_i.lim_x));
  assign take_y  = (trial_y <= 7'(TTSD_STICK_MAX)) && (prod_y <= 48'(item_i.lim_y));

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  // update k and prepare the odd square of the next trial
  always_comb begin
    item_d       = item_i;
    item_d.k_x   = take_x ? trial_x : item_i.k_x;
    item_d.k_y   = take_y ? trial_y : item_i.k_y;
    item_d.osq_x = take_x ? odd_sq(trial_x | NextStep) : odd_sq(item_i.k_x | NextStep);
    item_d.osq_y = take_y ? odd_sq(trial_y | NextStep) : odd_sq(item_i.k_y | NextStep);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      item_q <= item_d;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

// ----- rtl/touch_to_stick_deadzone.sv -----
// ----------------------------------------------------------------------------
// touch_to_stick_deadzone
// Maps a touch offset to a pair of stick values in -80..80 with a radial
// clamp to the configured radius and a per-axis deadzone.
// ----------------------------------------------------------------------------
// stages: 4 front, 7 search, 1 output register; one item per cycle, but
//   the whole pipeline holds while a finished result waits at the output
// reset: pipeline empty, stick_radius back to 1600
module touch_to_stick_deadzone #(
  parameter int unsigned COORD_FRAC_BITS = ttsd_pkg::TTSD_COORD_FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] touch_dx_i,
  input  logic signed [15:0] touch_dy_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [7:0]  stick_x_o,
  output logic signed [7:0]  stick_y_o
);
  import ttsd_pkg::*;

  logic [15:0] radius_q;
  logic        adv;
  logic        out_valid_q;
  logic [7:0]  stick_x_q, stick_y_q;

  logic [TTSD_KBITS:0] vld_s;
  ttsd_srch_t          item_s [TTSD_KBITS+1];

  // signed stick value from magnitude, sign and zero flag
  function automatic logic [7:0] stick_val(input logic kill, input logic neg,
                                           input logic [6:0] k);
    logic [7:0] mag;
    mag = kill ? 8'd0 : {1'b0, k};
    return neg ? 8'(-mag) : mag;
  endfunction

  // configuration register, the only one, at every word offset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= TTSD_RADIUS_RESET;
    end else if (psel && penable && pwrite) begin
      radius_q <= pwdata[15:0];
    end
  end

  assign prdata = 32'(radius_q);
  assign pready = 1'b1;

  // pipeline advances unless a finished result is held at the output
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // front stages
  ttsd_front #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .vld_i   (in_valid_i),
    .dx_i    (touch_dx_i),
    .dy_i    (touch_dy_i),
    .radius_i(radius_q),
    .vld_o   (vld_s[0]),
    .item_o  (item_s[0])
  );

  // magnitude search, most significant bit first
  for (genvar g = 0; g < TTSD_KBITS; g++) begin : g_step
    ttsd_step #(
      .BIT(TTSD_KBITS - 1 - g)
    ) u_step (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .vld_i (vld_s[g]),
      .item_i(item_s[g]),
      .vld_o (vld_s[g+1]),
      .item_o(item_s[g+1])
    );
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld_s[TTSD_KBITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      stick_x_q <= stick_val(item_s[TTSD_KBITS].kill_x, item_s[TTSD_KBITS].neg_x,
                             item_s[TTSD_KBITS].k_x);
      stick_y_q <= stick_val(item_s[TTSD_KBITS].kill_y, item_s[TTSD_KBITS].neg_y,
                             item_s[TTSD_KBITS].k_y);
    end
  end

  assign out_valid_o = out_valid_q;
  assign stick_x_o   = stick_x_q;
  assign stick_y_o   = stick_y_q;

  // search never settles above full scale
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_s[TTSD_KBITS] |-> (item_s[TTSD_KBITS].k_x <= 7'(TTSD_STICK_MAX) &&
                           item_s[TTSD_KBITS].k_y <= 7'(TTSD_STICK_MAX)))
    else $error("search magnitude above full scale");

  // results stay within -80..80
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (stick_x_o <= 8'sd80 && stick_x_o >= -8'sd80 &&
                     stick_y_o <= 8'sd80 && stick_y_o >= -8'sd80))
    else $error("stick value out of range");

  // a result only appears when the last search stage held an item
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(vld_s[TTSD_KBITS]))
    else $error("result without an item in the pipeline");

endmodule

// ----- dv/touch_to_stick_deadzone_tb.sv -----
// ----------------------------------------------------------------------------
// touch_to_stick_deadzone_tb
// Self-checking bench for the touch-to-stick mapper: drives touch offsets
// over a valid/ready channel, programs the stick radius over the register
// port, predicts each stick pair with exact integer math and compares
// every result item in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module touch_to_stick_deadzone_tb;
  import ttsd_pkg::*;

  localparam logic [1:0] ADDR_STICK_RADIUS = 2'd0;
  localparam int PIPE_LATENCY = 12;
  localparam int HOLD_CYCLES  = 80;
  localparam int PHASE_ITEMS  = 70;

  typedef struct packed {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
  } touch_t;

  typedef struct packed {
    logic signed [7:0] x;
    logic signed [7:0] y;
  } stick_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [1:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] touch_dx_i = '0;
  logic signed [15:0] touch_dy_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [7:0]  stick_x_o;
  logic signed [7:0]  stick_y_o;

  touch_to_stick_deadzone dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .touch_dx_i  (touch_dx_i),
    .touch_dy_i  (touch_dy_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stick_x_o   (stick_x_o),
    .stick_y_o   (stick_y_o)
  );

  touch_t      touch_pending[$];
  stick_t      stick_expected[$];
  logic [15:0] radius_now = TTSD_RADIUS_RESET;
  bit          send_idle = 1'b0;
  bit          recv_idle = 1'b0;
  bit          hold_req = 1'b0;
  int          n_err = 0;
  int          n_in = 0;
  int          n_out = 0;
  int          n_radius = 0;
  int          send_gap_left = 0;
  int          recv_gap_left = 0;
  int          hold_left = 0;

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    n_err++;
  endtask

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap(input bit idle_on);
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // rounded 0..80 magnitude of one axis, signed back into 8 bits
  function automatic logic signed [7:0] axis_stick(input longint v,
                                                    input longint unsigned d2);
    longint unsigned a;
    longint unsigned lim;
    longint unsigned odd;
    int              k;
    logic [7:0]      m;
    a   = (v < 0) ? longint'(-v) : longint'(v);
    lim = 64'd25600 * a * a;
    k   = 0;
    if (64'd625 * a * a >= 64'd4 * d2) begin
      for (int t = 1; t <= TTSD_STICK_MAX; t++) begin
        odd = longint'(2 * t - 1);
        if (odd * odd * d2 <= lim) k = t;
        else break;
      end
    end
    m = 8'(k);
    return (v < 0) ? -m : m;
  endfunction

  // stick pair for one touch offset under a given radius
  function automatic stick_t map_touch(input touch_t tch, input logic [15:0] rad);
    longint          sx;
    longint          sy;
    longint unsigned r2;
    longint unsigned s;
    longint unsigned d2;
    stick_t          res;
    if (rad <= (16'd1 << TTSD_COORD_FRAC_BITS)) return '0;
    sx  = longint'(tch.dx);
    sy  = -longint'(tch.dy);
    r2  = longint'(rad) * longint'(rad);
    s   = sx * sx + sy * sy;
    d2  = (s > r2) ? s : r2;
    res.x = axis_stick(sx, d2);
    res.y = axis_stick(sy, d2);
    return res;
  endfunction

  function automatic logic signed [15:0] sat16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic longint rand_sign(input longint v);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // random touch offset shaped around the current radius
  function automatic touch_t rand_touch(input logic [15:0] rad);
    touch_t       tch;
    int           mode;
    longint       span;
    longint       a;
    int           k;
    logic [15:0]  corner[6];
    corner = '{16'h8000, 16'h8001, 16'hffff, 16'h0000, 16'h0001, 16'h7fff};
    span = longint'(rad) + longint'(rad) / 4 + 1;
    if (span > 32767) span = 32767;
    mode = $urandom_range(0, 9);
    case (mode)
      0, 1: begin
        tch.dx = 16'($urandom);
        tch.dy = 16'($urandom);
      end
      6, 7: begin
        // one axis right at the deadzone edge
        a = (2 * longint'(rad)) / 25 + longint'($urandom_range(0, 2)) - 1;
        tch.dx = sat16(rand_sign(a));
        tch.dy = sat16(longint'($urandom_range(0, 2 * span)) - span);
        if ($urandom_range(0, 1)) tch = '{tch.dy, tch.dx};
      end
      8: begin
        // one axis near a rounding tie
        k = $urandom_range(1, TTSD_STICK_MAX);
        a = (longint'(rad) * (2 * k - 1) + 80) / 160 + longint'($urandom_range(0, 2)) - 1;
        tch.dx = sat16(rand_sign(a));
        tch.dy = sat16(longint'($urandom_range(0, 4)) - 2);
        if ($urandom_range(0, 1)) tch = '{tch.dy, tch.dx};
      end
      9: begin
        tch.dx = corner[$urandom_range(0, 5)];
        tch.dy = corner[$urandom_range(0, 5)];
      end
      default: begin
        tch.dx = sat16(longint'($urandom_range(0, 2 * span)) - span);
        tch.dy = sat16(longint'($urandom_range(0, 2 * span)) - span);
      end
    endcase
    return tch;
  endfunction

  task automatic queue_touch(input int dx, input int dy);
    touch_pending.push_back('{16'(dx), 16'(dy)});
  endtask

  // wait until nothing is pending, offered or outstanding
  task automatic wait_drained();
    do @(negedge clk_i);
    while (touch_pending.size() != 0 || in_valid_i || stick_expected.size() != 0);
  endtask

  // register write then read back, each with a setup and an access phase
  task automatic write_radius(input logic [15:0] rad);
    logic [31:0] rd;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_STICK_RADIUS;
    pwdata  <= {16'($urandom), rad};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    radius_now = rad;
    n_radius++;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[15:0] !== rad) report_mismatch("stick_radius readback", rd[15:0], rad);
  endtask

  // sender: pops pending items, predicts on accept
  always @(posedge clk_i) begin : sender
    touch_t tch;
    logic   nxt_valid;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        stick_expected.push_back(map_touch('{touch_dx_i, touch_dy_i}, radius_now));
        n_in++;
      end
      if (!(in_valid_i && !in_ready_o)) begin
        nxt_valid = 1'b0;
        if (send_gap_left != 0) begin
          send_gap_left--;
        end else if (touch_pending.size() != 0) begin
          tch = touch_pending.pop_front();
          touch_dx_i <= tch.dx;
          touch_dy_i <= tch.dy;
          nxt_valid = 1'b1;
          send_gap_left = pick_gap(send_idle);
        end
        in_valid_i <= nxt_valid;
      end
    end
  end

  // receiver: checks results, drives ready with gaps and the long hold-off
  always @(posedge clk_i) begin : receiver
    stick_t want;
    logic   rdy;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_out++;
        if (stick_expected.size() == 0) begin
          report_mismatch("result with nothing expected, stick_x", stick_x_o, 0);
        end else begin
          want = stick_expected.pop_front();
          if (stick_x_o !== want.x) report_mismatch("stick_x", stick_x_o, want.x);
          if (stick_y_o !== want.y) report_mismatch("stick_y", stick_y_o, want.y);
        end
      end
      rdy = 1'b0;
      if (hold_left != 0) begin
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end else if (recv_gap_left != 0) begin
        recv_gap_left--;
      end else begin
        rdy = 1'b1;
        recv_gap_left = pick_gap(recv_idle);
      end
      out_ready_i <= rdy;
    end
  end

  // stimulus
  initial begin
    logic [15:0] radius_list[11];
    radius_list = '{16'd17, 16'hffff, 16'd0, 16'd16, 16'd1600, 16'd1, 16'd40,
                    16'($urandom_range(17, 4000)), 16'($urandom),
                    16'($urandom_range(17, 300)), 16'd300};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed items under the reset radius
    queue_touch(0, 0);
    queue_touch(32767, 0);
    queue_touch(-32768, 0);
    queue_touch(0, -32768);
    queue_touch(0, 32767);
    queue_touch(-32768, -32768);
    queue_touch(32767, 32767);
    queue_touch(32767, -32768);
    queue_touch(128, 0);
    queue_touch(127, 0);
    queue_touch(-128, -127);
    queue_touch(0, 128);
    queue_touch(150, -150);
    queue_touch(-150, 150);
    queue_touch(1600, 0);
    queue_touch(0, -1600);
    queue_touch(1131, 1131);
    queue_touch(-1, 1);
    queue_touch(1601, 0);
    queue_touch(170, 2000);
    wait_drained();
    repeat (PIPE_LATENCY + 4) @(posedge clk_i);

    foreach (radius_list[p]) begin
      write_radius(radius_list[p]);
      send_idle = p[0];
      recv_idle = (p % 3) != 0;
      if (p == 4) begin
        // fill the pipe against a stalled receiver
        send_idle = 1'b0;
        hold_req  = 1'b1;
        repeat (40) touch_pending.push_back(rand_touch(radius_now));
        wait_drained();
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2 && p[0]) wait_drained();
        touch_pending.push_back(rand_touch(radius_now));
      end
      wait_drained();
      repeat (PIPE_LATENCY + 4) @(posedge clk_i);
    end

    wait_drained();
    repeat (PIPE_LATENCY + 20) @(posedge clk_i);
    if (stick_expected.size() != 0)
      report_mismatch("results never delivered", 0, stick_expected.size());
    $display("run covered %0d touch items and %0d stick results over %0d radius settings",
             n_in, n_out, n_radius);
    $display("including small radii, full-scale offsets, deadzone edges and rounding ties");
    if (n_err == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ttsd_pkg.sv
rtl/ttsd_front.sv
rtl/ttsd_step.sv
rtl/touch_to_stick_deadzone.sv
dv/touch_to_stick_deadzone_tb.sv
